// ===== sv/s384_pkg.sv =====
package s384_pkg;

    localparam int NumRounds = 80;

    typedef logic [63:0] word_t;

    // One queued beat: message bytes already cut to the valid count.
    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  nbytes;
        logic        last;
    } beat_t;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } core_state_t;

    localparam word_t IV [8] = '{
        64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17,
        64'h152fecd8f70e5939, 64'h67332667ffc00b31, 64'h8eb44a8768581511,
        64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
    };

    localparam word_t K [80] = '{
        64'h428a2f98d728ae22,64'h7137449123ef65cd,64'hb5c0fbcfec4d3b2f,64'he9b5dba58189dbbc,
        64'h3956c25bf348b538,64'h59f111f1b605d019,64'h923f82a4af194f9b,64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242,64'h12835b0145706fbe,64'h243185be4ee4b28c,64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f,64'h80deb1fe3b1696b1,64'h9bdc06a725c71235,64'hc19bf174cf692694,
        64'he49b69c19ef14ad2,64'hefbe4786384f25e3,64'h0fc19dc68b8cd5b5,64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275,64'h4a7484aa6ea6e483,64'h5cb0a9dcbd41fbd4,64'h76f988da831153b5,
        64'h983e5152ee66dfab,64'ha831c66d2db43210,64'hb00327c898fb213f,64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2,64'hd5a79147930aa725,64'h06ca6351e003826f,64'h142929670a0e6e70,
        64'h27b70a8546d22ffc,64'h2e1b21385c26c926,64'h4d2c6dfc5ac42aed,64'h53380d139d95b3df,
        64'h650a73548baf63de,64'h766a0abb3c77b2a8,64'h81c2c92e47edaee6,64'h92722c851482353b,
        64'ha2bfe8a14cf10364,64'ha81a664bbc423001,64'hc24b8b70d0f89791,64'hc76c51a30654be30,
        64'hd192e819d6ef5218,64'hd69906245565a910,64'hf40e35855771202a,64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8,64'h1e376c085141ab53,64'h2748774cdf8eeb99,64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63,64'h4ed8aa4ae3418acb,64'h5b9cca4f7763e373,64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc,64'h78a5636f43172f60,64'h84c87814a1f0ab72,64'h8cc702081a6439ec,
        64'h90befffa23631e28,64'ha4506cebde82bde9,64'hbef9a3f7b2c67915,64'hc67178f2e372532b,
        64'hca273eceea26619c,64'hd186b8c721c0c207,64'heada7dd6cde0eb1e,64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba,64'h0a637dc5a2c898a6,64'h113f9804bef90dae,64'h1b710b35131c471b,
        64'h28db77f523047d84,64'h32caab7b40c72493,64'h3c9ebe0a15c9bebc,64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6,64'h597f299cfc657e2a,64'h5fcb6fab3ad6faec,64'h6c44198c4a475817
    };

endpackage

// ===== sv/s384_front.sv =====
module s384_front
    import s384_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    output logic        ready,
    input  logic [63:0] message_word,
    input  logic [3:0]  valid_bytes,
    input  logic        last_word,
    output logic        q_valid,
    input  logic        q_ready,
    output beat_t       q_beat
);

    // Two-entry queue; clamps the byte count and zeroes unused bytes.
    beat_t      mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    beat_t      clean;
    logic [3:0] n;
    logic       push, pop;

    always_comb
    begin
        n = (valid_bytes > 4'd8) ? 4'd8 : valid_bytes;
        clean.nbytes = n;
        clean.last   = last_word;
        for (int i = 0; i < 8; i++)
        begin
            clean.data[63-8*i -: 8] = (i < int'(n)) ? message_word[63-8*i -: 8] : 8'h00;
        end
    end

    assign ready   = (cnt_reg != 2'd2);
    assign push    = valid && ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_beat  = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= clean;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== sv/s384_core.sv =====
module s384_core
    import s384_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    output logic        q_ready,
    input  beat_t       q_beat,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] digest_word,
    output logic [2:0]  word_index,
    output logic        digest_last
);

    core_state_t state_reg, state_next;

    word_t       h_reg [8];
    word_t       v_reg [8];
    word_t       w_reg [16];       // schedule window, w_reg[0] is current word
    logic [6:0]  fill_reg;
    logic [127:0] len_reg;
    logic [6:0]  rnd_reg;
    logic        final_reg;        // current compression ends the message
    logic        pad_done_reg;     // 0x80 already placed
    logic        pend_reg;         // last beat filled the block exactly, padding still due
    logic [2:0]  oidx_reg;

    // byte packing of a queued beat into the block
    logic [7:0]   pos;
    logic [3:0]   take;
    logic [3:0]   rest;
    logic         fill_wrap;

    word_t t1, t2, s0, s1, wnew, e, a;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_FILL:
            begin
                if (q_valid && fill_wrap)
                begin
                    state_next = ST_ROUND;
                end
                else if (q_valid && q_beat.last && (rest == 4'd0) && !fill_wrap)
                begin
                    state_next = ST_PAD;
                end
            end
            ST_PAD:   state_next = ST_ROUND;
            ST_ROUND:
            begin
                if (rnd_reg == 7'(NumRounds - 1))
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:   state_next = final_reg ? ST_OUT
                                 : ((pad_done_reg || pend_reg) ? ST_PAD : ST_FILL);
            ST_OUT:
            begin
                if (out_ready && oidx_reg == 3'd5)
                begin
                    state_next = ST_FILL;
                end
            end
            default:  state_next = ST_FILL;
        endcase
    end

    // bytes of the head beat that fit into this block
    always_comb
    begin
        pos  = {1'b0, fill_reg};
        take = ((8'd128 - pos) < {4'd0, q_beat.nbytes}) ? 4'((8'd128 - pos))
                                                         : q_beat.nbytes;
        rest = q_beat.nbytes - take;
        fill_wrap = (pos + {4'd0, take}) == 8'd128;
    end

    // partial beat leftover sits in the queue head as rest bytes
    logic [3:0]  used_reg;
    logic [63:0] shifted;
    logic [3:0]  avail;
    always_comb
    begin
        shifted = q_beat.data << {used_reg, 3'b000};
        avail   = q_beat.nbytes - used_reg;
    end

    logic [3:0] tk;
    logic       wrap2;
    always_comb
    begin
        tk    = ((8'd128 - pos) < {4'd0, avail}) ? 4'((8'd128 - pos)) : avail;
        wrap2 = (pos + {4'd0, tk}) == 8'd128;
    end

    assign q_ready = (state_reg == ST_FILL) && (tk == avail) && !(wrap2 && 1'b0);

    assign out_valid   = (state_reg == ST_OUT);
    assign digest_word = h_reg[oidx_reg];
    assign word_index  = oidx_reg;
    assign digest_last = (oidx_reg == 3'd5);

    always_comb
    begin
        e  = v_reg[4];
        a  = v_reg[0];
        t1 = v_reg[7] + ({e[13:0], e[63:14]} ^ {e[17:0], e[63:18]} ^ {e[40:0], e[63:41]})
             + ((e & v_reg[5]) ^ (~e & v_reg[6])) + K[rnd_reg] + w_reg[0];
        t2 = ({a[27:0], a[63:28]} ^ {a[33:0], a[63:34]} ^ {a[38:0], a[63:39]})
             + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        s0 = {w_reg[1][0], w_reg[1][63:1]} ^ {w_reg[1][7:0], w_reg[1][63:8]}
             ^ (w_reg[1] >> 7);
        s1 = {w_reg[14][18:0], w_reg[14][63:19]} ^ {w_reg[14][60:0], w_reg[14][63:61]}
             ^ (w_reg[14] >> 6);
        wnew = s1 + w_reg[9] + s0 + w_reg[0];
    end

    logic [127:0] bits_add;
    assign bits_add = {121'd0, tk, 3'b000};

    // writes one byte lane group into buffer
    function automatic word_t put_bytes(word_t old, logic [63:0] src, logic [2:0] off,
                                        logic [3:0] cnt);
        word_t r;
        r = old;
        for (int i = 0; i < 8; i++)
        begin
            if (i >= int'(off) && i < int'(off) + int'(cnt))
            begin
                r[63-8*i -: 8] = src[63-8*(i-int'(off)) -: 8];
            end
        end
        return r;
    endfunction

    logic [3:0] first_n;
    always_comb
    begin
        first_n = ({1'b0, tk} + {2'b0, pos[2:0]} > 5'd8) ? 4'(8 - int'(pos[2:0])) : tk;
    end

    // length fits in this block when the 0x80 lands before byte 112
    logic final_pad;
    assign final_pad = pad_done_reg ? 1'b1 : (pos < 8'd112);

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_FILL:
            begin
                if (q_valid && tk != 4'd0)
                begin
                    w_reg[pos[6:3]] <= put_bytes(w_reg[pos[6:3]], shifted, pos[2:0], first_n);
                    if (tk > first_n)
                    begin
                        w_reg[4'(pos[6:3] + 4'd1)] <= put_bytes(64'd0,
                            shifted << {first_n, 3'b000}, 3'd0, tk - first_n);
                    end
                end
                if (q_valid && wrap2)
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        v_reg[i] <= h_reg[i];
                    end
                end
            end
            ST_PAD:
            begin
                // place 0x80 if not yet, zero to 112 or 128, length if room
                for (int i = 0; i < 16; i++)
                begin
                    if (!pad_done_reg && i == int'(pos[6:3]))
                    begin
                        w_reg[i] <= put_bytes(w_reg[i] & ~(64'hFFFF_FFFF_FFFF_FFFF
                                    >> {pos[2:0], 3'b000}), 64'h80 << 56, pos[2:0], 4'd1);
                    end
                    else if ((pad_done_reg || i > int'(pos[6:3])) && i < 14)
                    begin
                        w_reg[i] <= 64'd0;
                    end
                    else if ((pad_done_reg || i > int'(pos[6:3])) && i >= 14 && !final_pad)
                    begin
                        w_reg[i] <= 64'd0;
                    end
                end
                if (final_pad)
                begin
                    w_reg[14] <= len_reg[127:64];
                    w_reg[15] <= len_reg[63:0];
                end
                for (int i = 0; i < 8; i++)
                begin
                    v_reg[i] <= h_reg[i];
                end
            end
            ST_ROUND:
            begin
                v_reg[7] <= v_reg[6];
                v_reg[6] <= v_reg[5];
                v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2];
                v_reg[2] <= v_reg[1];
                v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + t2;
                for (int i = 0; i < 15; i++)
                begin
                    w_reg[i] <= w_reg[i+1];
                end
                w_reg[15] <= wnew;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_FILL;
            fill_reg     <= '0;
            len_reg      <= '0;
            rnd_reg      <= '0;
            final_reg    <= 1'b0;
            pad_done_reg <= 1'b0;
            pend_reg     <= 1'b0;
            oidx_reg     <= '0;
            used_reg     <= '0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= IV[i];
            end
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_FILL:
                begin
                    if (q_valid)
                    begin
                        len_reg  <= len_reg + bits_add;
                        fill_reg <= 7'(pos + {4'd0, tk});
                        used_reg <= (tk == avail) ? 4'd0 : used_reg + tk;
                        if (wrap2)
                        begin
                            final_reg <= 1'b0;
                            pend_reg  <= q_beat.last && (tk == avail);
                        end
                    end
                end
                ST_PAD:
                begin
                    final_reg    <= final_pad;
                    pad_done_reg <= !final_pad;
                    pend_reg     <= 1'b0;
                    fill_reg     <= '0;
                end
                ST_ROUND:
                begin
                    rnd_reg <= (rnd_reg == 7'(NumRounds - 1)) ? 7'd0 : rnd_reg + 7'd1;
                end
                ST_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    end
                end
                ST_OUT:
                begin
                    if (out_ready)
                    begin
                        oidx_reg <= (oidx_reg == 3'd5) ? 3'd0 : oidx_reg + 3'd1;
                        if (oidx_reg == 3'd5)
                        begin
                            len_reg      <= '0;
                            fill_reg     <= '0;
                            pad_done_reg <= 1'b0;
                            final_reg    <= 1'b0;
                            for (int i = 0; i < 8; i++)
                            begin
                                h_reg[i] <= IV[i];
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

// ===== sv/sha384_hash_engine.sv =====
// SHA-384 engine. Message beats (big-endian 64-bit words, valid_bytes leading
// bytes, last_word on the final beat) enter a two-entry queue and are packed
// into 128-byte blocks at one beat per cycle while the core fills a block;
// each block then runs its 80 rounds at one round per cycle and is folded
// into the hash, and no beats leave the queue meanwhile. After the last beat
// each padding block is set up, run through 80 rounds and folded, then six
// digest words come out, word_index 0 first, digest_last on the sixth.
module sha384_hash_engine
    import s384_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] message_word,
    input  logic [3:0]  valid_bytes,
    input  logic        last_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] digest_word,
    output logic [2:0]  word_index,
    output logic        digest_last
);

    logic  q_valid, q_ready;
    beat_t q_beat;

    s384_front u_front (
        .clk, .rst_n,
        .valid(in_valid), .ready(in_ready),
        .message_word, .valid_bytes, .last_word,
        .q_valid, .q_ready, .q_beat
    );

    s384_core u_core (
        .clk, .rst_n,
        .q_valid, .q_ready, .q_beat,
        .out_valid, .out_ready,
        .digest_word, .word_index, .digest_last
    );

endmodule

// ===== verif/sha384_hash_engine_tb.sv =====
`timescale 1ns / 1ps

module sha384_hash_engine_tb;
    import s384_pkg::*;

    typedef struct {
        logic [63:0] data;
        logic [3:0]  nbytes;
        logic        last;
    } msg_beat_t;

    typedef struct {
        logic [63:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_beat_t;

    localparam int CycleLimit = 600000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [63:0] message_word;
    logic [3:0]  valid_bytes;
    logic        last_word;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_last;

    sha384_hash_engine DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .message_word (message_word),
        .valid_bytes  (valid_bytes),
        .last_word    (last_word),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .digest_word  (digest_word),
        .word_index   (word_index),
        .digest_last  (digest_last)
    );

    // predictor state
    logic [63:0]  hash_h [8];
    logic [63:0]  blk [16];
    int unsigned  blk_fill;
    logic [127:0] bit_len;

    msg_beat_t    beat_queue [$];
    digest_beat_t digest_queue [$];
    int           error_count;
    int           cycle_count;
    int           sent_count;
    bit           hold_off;
    bit           quiet;

    function automatic logic [63:0] rotr64(logic [63:0] x, int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    task automatic compress_block();
        logic [63:0] w [80];
        logic [63:0] v [8];
        logic [63:0] t1;
        logic [63:0] t2;
        for (int i = 0; i < 16; i++)
            w[i] = blk[i];
        for (int i = 16; i < 80; i++)
            w[i] = (rotr64(w[i-2], 19) ^ rotr64(w[i-2], 61) ^ (w[i-2] >> 6)) + w[i-7]
                 + (rotr64(w[i-15], 1) ^ rotr64(w[i-15], 8) ^ (w[i-15] >> 7)) + w[i-16];
        for (int i = 0; i < 8; i++)
            v[i] = hash_h[i];
        for (int r = 0; r < 80; r++)
        begin
            t1 = v[7] + (rotr64(v[4], 14) ^ rotr64(v[4], 18) ^ rotr64(v[4], 41))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K[r] + w[r];
            t2 = (rotr64(v[0], 28) ^ rotr64(v[0], 34) ^ rotr64(v[0], 39))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_h[i] += v[i];
    endtask

    task automatic push_byte(logic [7:0] b);
        blk[blk_fill >> 3][(7 - (blk_fill & 7)) * 8 +: 8] = b;
        blk_fill++;
        if (blk_fill == 128)
        begin
            compress_block();
            blk_fill = 0;
        end
    endtask

    task automatic start_digest();
        for (int i = 0; i < 8; i++)
            hash_h[i] = IV[i];
        blk_fill = 0;
        bit_len  = '0;
    endtask

    task automatic predict_digest(msg_beat_t b);
        int           n;
        logic [127:0] len;
        digest_beat_t d;
        n = (b.nbytes > 8) ? 8 : b.nbytes;
        for (int i = 0; i < n; i++)
            push_byte(b.data[63 - 8*i -: 8]);
        bit_len += 128'(n * 8);
        if (!b.last)
            return;
        len = bit_len;
        push_byte(8'h80);
        while (blk_fill != 112)
            push_byte(8'h00);
        blk[14] = len[127:64];
        blk[15] = len[63:0];
        compress_block();
        for (int i = 0; i < 6; i++)
        begin
            d.word = hash_h[i];
            d.idx  = 3'(i);
            d.last = (i == 5);
            digest_queue.push_back(d);
        end
        start_digest();
    endtask

    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic add_beat(logic [63:0] data, logic [3:0] nb, logic last);
        msg_beat_t b;
        b.data = data; b.nbytes = nb; b.last = last;
        beat_queue.push_back(b);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic add_message(int nwords);
        for (int i = 0; i < nwords - 1; i++)
            add_beat(rand64(), 4'd8, 1'b0);
        add_beat(rand64(), 4'($urandom_range(0, 8)), 1'b1);
    endtask

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            message_word <= '0;
            valid_bytes  <= '0;
            last_word    <= 1'b0;
        end
        else
        begin
            if (!in_valid || in_ready)
            begin
                if (beat_queue.size() > 0 && !hold_off
                    && (quiet || $urandom_range(0, 99) >= 35))
                begin
                    msg_beat_t b;
                    b = beat_queue.pop_front();
                    predict_digest(b);
                    sent_count++;
                    // no idling on either side for a stretch of beats
                    quiet        <= (sent_count >= 200 && sent_count < 260);
                    in_valid     <= 1'b1;
                    message_word <= b.data;
                    valid_bytes  <= b.nbytes;
                    last_word    <= b.last;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (digest_queue.size() == 0)
                    report_mismatch($sformatf("unexpected digest word %h", digest_word));
                else
                begin
                    digest_beat_t e;
                    e = digest_queue.pop_front();
                    if (digest_word !== e.word)
                        report_mismatch($sformatf("digest_word %h exp %h", digest_word, e.word));
                    if (word_index !== e.idx)
                        report_mismatch($sformatf("word_index %0d exp %0d", word_index, e.idx));
                    if (digest_last !== e.last)
                        report_mismatch($sformatf("digest_last %b exp %b", digest_last, e.last));
                end
            end
            out_ready <= quiet || ($urandom_range(0, 99) >= 35);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int n;
        logic [3:0] nb;
        error_count = 0;
        cycle_count = 0;
        sent_count  = 0;
        hold_off    = 0;
        quiet       = 0;
        in_valid = 0; message_word = '0; valid_bytes = '0; last_word = 0; out_ready = 0;
        start_digest();
        for (int i = 0; i < 16; i++)
            blk[i] = '0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty message, "abc", field extremes, oversized counts
        add_beat(64'h0, 4'd0, 1'b1);
        add_beat(64'h6162_6300_0000_0000, 4'd3, 1'b1);
        add_beat(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1);
        add_beat(64'h0, 4'd8, 1'b1);
        add_beat(64'hA5A5_5A5A_FFFF_0000, 4'd15, 1'b0);
        add_beat(64'h0123_4567_89AB_CDEF, 4'd9, 1'b0);
        add_beat(64'hDEAD_BEEF_0000_0000, 4'd0, 1'b0);
        add_beat(64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 1'b0);
        add_beat(64'h1122_3344_5566_7788, 4'd7, 1'b1);
        // 112 and 111 bytes: padding spills into an extra block / just fits
        for (int i = 0; i < 13; i++)
            add_beat(rand64(), 4'd8, 1'b0);
        add_beat(rand64(), 4'd8, 1'b1);
        for (int i = 0; i < 13; i++)
            add_beat(rand64(), 4'd8, 1'b0);
        add_beat(rand64(), 4'd7, 1'b1);
        // exactly one block: last beat closes the block
        for (int i = 0; i < 15; i++)
            add_beat(rand64(), 4'd8, 1'b0);
        add_beat(rand64(), 4'd8, 1'b1);

        // random: mostly full-word messages of assorted length, some short beats
        n = beat_queue.size();
        while (n < 420)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                int k;
                k = $urandom_range(1, 6);
                for (int i = 0; i < k; i++)
                begin
                    nb = 4'($urandom_range(0, 15));
                    add_beat(rand64(), nb, (i == k - 1));
                end
                n += k;
            end
            else
            begin
                int k;
                k = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 34) : $urandom_range(1, 17);
                add_message(k);
                n += k;
            end
            // pause until the engine has drained
            if (n > 100 && n < 140)
            begin
                wait (beat_queue.size() == 0);
                hold_off = 1;
                wait (digest_queue.size() == 0);
                @(posedge clk);
                hold_off <= 0;
            end
        end

        wait (beat_queue.size() == 0 && !in_valid);
        wait (digest_queue.size() == 0);
        repeat (400) @(posedge clk);
        if (error_count == 0 && digest_queue.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
